@@ rtl/core/sla_pkg.sv @@
package sla_pkg;

    localparam int GRID_LOG = 6;
    localparam int GRID = 1 << GRID_LOG;
    localparam int CELL_W = 2 * GRID_LOG;
    localparam int Q_W = 32;
    localparam int V_W = 16;
    localparam int C_W = 16;
    localparam int W_W = 17;
    localparam int PW_W = 33;
    localparam int ACC_W = 66;
    localparam int PROD_W = 67;
    localparam int PADDR_W = 4;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] REG_COURANT_X = 2'd0;
    localparam logic [1:0] REG_COURANT_Y = 2'd1;
    localparam logic [1:0] REG_SCHEME_MODE = 2'd2;

    localparam logic [C_W-1:0] COURANT_RESET = 16'd6554;
    localparam logic [W_W-1:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] row;
        logic [5:0] col;
        logic signed [15:0] u_value;
        logic signed [15:0] v_value;
        logic signed [31:0] q_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] q_out;
        logic step_done;
    } res_t;

    typedef struct packed {
        logic acc_clr;
        logic acc_add;
    } mac_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_SW_RD, ST_SW_WR,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
        ST_P7, ST_P8, ST_P9, ST_P10, ST_P11, ST_P12
    } st_t;

    typedef enum logic [2:0] {
        JOB_SAVE, JOB_PASS_FWD, JOB_PASS_BWD, JOB_COPY, JOB_CORR, JOB_END
    } job_t;

    function automatic job_t job_of(input logic mode, input logic [3:0] stage);
        job_t j;
        j = JOB_END;
        if (!mode) begin
            case (stage)
                4'd0: j = JOB_PASS_FWD;
                4'd1: j = JOB_COPY;
                default: j = JOB_END;
            endcase
        end else begin
            case (stage)
                4'd0: j = JOB_SAVE;
                4'd1: j = JOB_PASS_FWD;
                4'd2: j = JOB_COPY;
                4'd3: j = JOB_PASS_BWD;
                4'd4: j = JOB_COPY;
                4'd5: j = JOB_CORR;
                4'd6: j = JOB_PASS_FWD;
                4'd7: j = JOB_COPY;
                default: j = JOB_END;
            endcase
        end
        return j;
    endfunction

    function automatic logic [W_W-1:0] sat_weight(input logic [20:0] t);
        logic [20:0] one_ext;
        one_ext = {4'd0, ONE_Q16};
        if (t > one_ext) begin
            return '0;
        end
        return W_W'(one_ext - t);
    endfunction

endpackage

@@ rtl/core/sla_ram.sv @@
module sla_ram #(
    parameter int WIDTH = 32,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/sla_mac.sv @@
module sla_mac (
    input  logic                                clk,
    input  sla_pkg::mac_ctl_t                   ctl,
    input  logic signed [32:0]                  op_a,
    input  logic signed [33:0]                  op_b,
    output logic signed [sla_pkg::PROD_W-1:0]   prod,
    output logic signed [sla_pkg::ACC_W-1:0]    acc
);
    import sla_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (ctl.acc_clr)
        begin
            acc_reg <= prod_reg[ACC_W-1:0];
        end
        else if (ctl.acc_add)
        begin
            acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
        end
    end

    assign prod = prod_reg;
    assign acc = acc_reg;
endmodule

@@ rtl/core/semi_lagrangian_advection_grid.sv @@
// Write items (load u, v, q of one cell) and read items (return q of one cell in
// the next cycle) go at one item per cycle with busy low; every item gives exactly
// one result, shown for one cycle with done high, which the receiver must take
// as it comes. A run item holds busy for the whole time step, set by one shared
// multiplier visited in states P0 to P12 per interior cell and by sweeps of a read
// and a write state over all 4096 cells (save, copy back, correct), more of them in
// mode 1 than in mode 0; then done rises with step_done high.
module semi_lagrangian_advection_grid (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  sla_pkg::cmd_t                      cmd,
    output logic                               done,
    output sla_pkg::res_t                      result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sla_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import sla_pkg::*;

    st_t state_reg, state_next;
    logic [3:0] stage_reg, stage_next;
    logic [GRID_LOG-1:0] row_reg, row_next, col_reg, col_next;
    logic [GRID_LOG-1:0] ri_reg, ri_next, cj_reg, cj_next;
    logic [CELL_W-1:0] cnt_reg, cnt_next;
    logic di_pos_reg, di_pos_next, dj_pos_reg, dj_pos_next;
    logic [W_W-1:0] magv_reg, magv_next, a_reg, a_next, b_reg, b_next;
    logic [PW_W-1:0] w0_reg, w0_next, w1_reg, w1_next, w2_reg, w2_next, w3_reg, w3_next;
    logic [Q_W-1:0] qc_reg, qc_next, qi_reg, qi_next, qj_reg, qj_next, qd_reg, qd_next;
    logic [C_W-1:0] cx_reg, cy_reg;
    logic mode_reg;
    logic done_reg, done_next, stepd_reg, stepd_next, rdp_reg, rdp_next;

    logic f_we, s_we, sv_we, v_we;
    logic [CELL_W-1:0] f_waddr, f_raddr, s_waddr;
    logic [Q_W-1:0] f_wdata, f_rd, s_wdata, s_rd, sv_wdata, sv_rd;
    logic [V_W-1:0] u_rd, v_rd;

    mac_ctl_t mctl;
    logic signed [32:0] op_a;
    logic signed [33:0] op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0] acc;

    logic accept, cfg_wr;
    job_t job;
    logic dir_neg;
    logic signed [16:0] u_ext, v_ext, uu, vv;
    logic [W_W-1:0] magu, magv, bsat, na, nb;
    logic [ACC_W-1:0] rnd;
    logic signed [32:0] dq;
    logic signed [33:0] corr;
    logic border;

    sla_ram #(.WIDTH(V_W), .ADDR_W(CELL_W)) u_vx (
        .clk(clk), .we(v_we), .waddr({cmd.row, cmd.col}), .wdata(cmd.u_value),
        .raddr({row_reg, col_reg}), .rdata(u_rd)
    );
    sla_ram #(.WIDTH(V_W), .ADDR_W(CELL_W)) u_vy (
        .clk(clk), .we(v_we), .waddr({cmd.row, cmd.col}), .wdata(cmd.v_value),
        .raddr({row_reg, col_reg}), .rdata(v_rd)
    );
    sla_ram #(.WIDTH(Q_W), .ADDR_W(CELL_W)) u_field (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rd)
    );
    sla_ram #(.WIDTH(Q_W), .ADDR_W(CELL_W)) u_saved (
        .clk(clk), .we(sv_we), .waddr(cnt_reg), .wdata(sv_wdata),
        .raddr(cnt_reg), .rdata(sv_rd)
    );
    sla_ram #(.WIDTH(Q_W), .ADDR_W(CELL_W)) u_scratch (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(cnt_reg), .rdata(s_rd)
    );

    sla_mac u_mac (
        .clk(clk), .ctl(mctl), .op_a(op_a), .op_b(op_b), .prod(prod), .acc(acc)
    );

    assign busy = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_COURANT_X: prdata = {16'd0, cx_reg};
            REG_COURANT_Y: prdata = {16'd0, cy_reg};
            REG_SCHEME_MODE: prdata = {31'd0, mode_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= COURANT_RESET;
            cy_reg <= COURANT_RESET;
            mode_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_COURANT_X: cx_reg <= pwdata[C_W-1:0];
                REG_COURANT_Y: cy_reg <= pwdata[C_W-1:0];
                REG_SCHEME_MODE: mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign job = job_of(mode_reg, stage_reg);
    assign dir_neg = (job == JOB_PASS_BWD);
    assign u_ext = {u_rd[15], u_rd};
    assign v_ext = {v_rd[15], v_rd};
    assign uu = dir_neg ? -u_ext : u_ext;
    assign vv = dir_neg ? -v_ext : v_ext;
    assign magu = uu[16] ? W_W'(-uu) : W_W'(uu);
    assign magv = vv[16] ? W_W'(-vv) : W_W'(vv);
    assign bsat = sat_weight(prod[32:12]);
    assign na = ONE_Q16 - a_reg;
    assign nb = ONE_Q16 - b_reg;
    assign rnd = acc + (ACC_W'(1) << 31);
    assign dq = {sv_rd[31], sv_rd} - {f_rd[31], f_rd};
    assign corr = {{2{sv_rd[31]}}, sv_rd} + {dq[32], (dq >>> 1)};
    assign border = (cnt_reg[CELL_W-1:GRID_LOG] == '0) || (&cnt_reg[CELL_W-1:GRID_LOG])
        || (cnt_reg[GRID_LOG-1:0] == '0) || (&cnt_reg[GRID_LOG-1:0]);

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        row_next = row_reg;
        col_next = col_reg;
        ri_next = ri_reg;
        cj_next = cj_reg;
        cnt_next = cnt_reg;
        di_pos_next = di_pos_reg;
        dj_pos_next = dj_pos_reg;
        magv_next = magv_reg;
        a_next = a_reg;
        b_next = b_reg;
        w0_next = w0_reg;
        w1_next = w1_reg;
        w2_next = w2_reg;
        w3_next = w3_reg;
        qc_next = qc_reg;
        qi_next = qi_reg;
        qj_next = qj_reg;
        qd_next = qd_reg;
        done_next = 1'b0;
        stepd_next = 1'b0;
        rdp_next = 1'b0;
        v_we = 1'b0;
        f_we = 1'b0;
        f_waddr = {cmd.row, cmd.col};
        f_wdata = cmd.q_value;
        f_raddr = {cmd.row, cmd.col};
        sv_we = 1'b0;
        sv_wdata = f_rd;
        s_we = 1'b0;
        s_waddr = {row_reg, col_reg};
        s_wdata = rnd[63:32];
        mctl = '0;
        op_a = '0;
        op_b = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    case (cmd.opcode)
                        OP_WRITE:
                        begin
                            v_we = 1'b1;
                            f_we = 1'b1;
                        end
                        OP_READ: rdp_next = 1'b1;
                        OP_RUN:
                        begin
                            done_next = 1'b0;
                            stage_next = '0;
                            state_next = ST_DISPATCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DISPATCH:
            begin
                cnt_next = '0;
                row_next = GRID_LOG'(1);
                col_next = GRID_LOG'(1);
                unique case (job)
                    JOB_SAVE, JOB_COPY, JOB_CORR: state_next = ST_SW_RD;
                    JOB_PASS_FWD, JOB_PASS_BWD: state_next = ST_P0;
                    JOB_END:
                    begin
                        done_next = 1'b1;
                        stepd_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_SW_RD:
            begin
                f_raddr = cnt_reg;
                state_next = ST_SW_WR;
            end
            ST_SW_WR:
            begin
                f_waddr = cnt_reg;
                if (job == JOB_SAVE)
                begin
                    sv_we = 1'b1;
                end
                else if (job == JOB_COPY)
                begin
                    f_we = 1'b1;
                    f_wdata = border ? '0 : s_rd;
                end
                else
                begin
                    f_we = 1'b1;
                    if (corr > 34'sh07FFFFFFF)
                        f_wdata = 32'h7FFFFFFF;
                    else if (corr < -34'sh080000000)
                        f_wdata = 32'h80000000;
                    else
                        f_wdata = corr[31:0];
                end
                if (&cnt_reg)
                begin
                    stage_next = stage_reg + 4'd1;
                    state_next = ST_DISPATCH;
                end
                else
                begin
                    cnt_next = cnt_reg + CELL_W'(1);
                    state_next = ST_SW_RD;
                end
            end
            ST_P0:
            begin
                f_raddr = {row_reg, col_reg};
                state_next = ST_P1;
            end
            ST_P1:
            begin
                qc_next = f_rd;
                di_pos_next = !uu[16] && (uu != '0);
                dj_pos_next = !vv[16] && (vv != '0);
                ri_next = (!uu[16] && (uu != '0)) ? row_reg - GRID_LOG'(1)
                                                  : row_reg + GRID_LOG'(1);
                cj_next = (!vv[16] && (vv != '0)) ? col_reg - GRID_LOG'(1)
                                                  : col_reg + GRID_LOG'(1);
                magv_next = magv;
                f_raddr = {ri_next, col_reg};
                op_a = {16'd0, magu};
                op_b = {18'd0, cx_reg};
                state_next = ST_P2;
            end
            ST_P2:
            begin
                qi_next = f_rd;
                a_next = sat_weight(prod[32:12]);
                f_raddr = {row_reg, cj_reg};
                op_a = {16'd0, magv_reg};
                op_b = {18'd0, cy_reg};
                state_next = ST_P3;
            end
            ST_P3:
            begin
                qj_next = f_rd;
                b_next = bsat;
                f_raddr = {ri_reg, cj_reg};
                op_a = {16'd0, a_reg};
                op_b = {17'd0, bsat};
                state_next = ST_P4;
            end
            ST_P4:
            begin
                qd_next = f_rd;
                w0_next = prod[PW_W-1:0];
                op_a = {16'd0, na};
                op_b = {17'd0, b_reg};
                state_next = ST_P5;
            end
            ST_P5:
            begin
                w1_next = prod[PW_W-1:0];
                op_a = {16'd0, a_reg};
                op_b = {17'd0, nb};
                state_next = ST_P6;
            end
            ST_P6:
            begin
                w2_next = prod[PW_W-1:0];
                op_a = {16'd0, na};
                op_b = {17'd0, nb};
                state_next = ST_P7;
            end
            ST_P7:
            begin
                w3_next = prod[PW_W-1:0];
                op_a = {qc_reg[31], qc_reg};
                op_b = {1'b0, w0_reg};
                state_next = ST_P8;
            end
            ST_P8:
            begin
                mctl.acc_clr = 1'b1;
                op_a = {qi_reg[31], qi_reg};
                op_b = {1'b0, w1_reg};
                state_next = ST_P9;
            end
            ST_P9:
            begin
                mctl.acc_add = 1'b1;
                op_a = {qj_reg[31], qj_reg};
                op_b = {1'b0, w2_reg};
                state_next = ST_P10;
            end
            ST_P10:
            begin
                mctl.acc_add = 1'b1;
                op_a = {qd_reg[31], qd_reg};
                op_b = {1'b0, w3_reg};
                state_next = ST_P11;
            end
            ST_P11:
            begin
                mctl.acc_add = 1'b1;
                state_next = ST_P12;
            end
            ST_P12:
            begin
                s_we = 1'b1;
                state_next = ST_P0;
                if (col_reg == GRID_LOG'(GRID - 2))
                begin
                    col_next = GRID_LOG'(1);
                    if (row_reg == GRID_LOG'(GRID - 2))
                    begin
                        stage_next = stage_reg + 4'd1;
                        state_next = ST_DISPATCH;
                    end
                    else
                    begin
                        row_next = row_reg + GRID_LOG'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + GRID_LOG'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stage_reg <= '0;
            done_reg <= 1'b0;
            stepd_reg <= 1'b0;
            rdp_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            done_reg <= done_next;
            stepd_reg <= stepd_next;
            rdp_reg <= rdp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        ri_reg <= ri_next;
        cj_reg <= cj_next;
        cnt_reg <= cnt_next;
        di_pos_reg <= di_pos_next;
        dj_pos_reg <= dj_pos_next;
        magv_reg <= magv_next;
        a_reg <= a_next;
        b_reg <= b_next;
        w0_reg <= w0_next;
        w1_reg <= w1_next;
        w2_reg <= w2_next;
        w3_reg <= w3_next;
        qc_reg <= qc_next;
        qi_reg <= qi_next;
        qj_reg <= qj_next;
        qd_reg <= qd_next;
    end

    assign done = done_reg;
    assign result.q_out = rdp_reg ? f_rd : '0;
    assign result.step_done = stepd_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.opcode == OP_RUN) |=> busy)
        else $error("run item did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.step_done |-> (done && !busy))
        else $error("step_done without strobe or while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (busy && state_reg != ST_DISPATCH) |-> !done)
        else $error("result shown in the middle of a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P12) |-> (di_pos_reg ? ri_reg == row_reg - GRID_LOG'(1)
                                              : ri_reg == row_reg + GRID_LOG'(1)))
        else $error("upwind row does not follow velocity sign");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P12) |-> (dj_pos_reg ? cj_reg == col_reg - GRID_LOG'(1)
                                              : cj_reg == col_reg + GRID_LOG'(1)))
        else $error("upwind column does not follow velocity sign");
endmodule

@@ verif/semi_lagrangian_advection_grid_tb.sv @@
module semi_lagrangian_advection_grid_tb;
    import sla_pkg::*;

    localparam int CELLS = GRID * GRID;
    localparam int CYCLE_LIMIT = 3000000;

    class advect_scoreboard;
        logic [15:0] vel_x[CELLS];
        logic [15:0] vel_y[CELLS];
        logic [31:0] field[CELLS];
        logic [15:0] cour_x;
        logic [15:0] cour_y;
        logic mode;
        res_t pending[$];
        int errors;

        function new();
            cour_x = COURANT_RESET;
            cour_y = COURANT_RESET;
            mode = 1'b1;
            errors = 0;
            foreach (field[k])
            begin
                vel_x[k] = '0;
                vel_y[k] = '0;
                field[k] = '0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_COURANT_X: cour_x = val[15:0];
                REG_COURANT_Y: cour_y = val[15:0];
                REG_SCHEME_MODE: mode = val[0];
                default: ;
            endcase
        endfunction

        function bit [63:0] blend_weight(int vel, logic [15:0] c);
            bit [31:0] mag;
            bit [31:0] t;
            mag = (vel < 0) ? -vel : vel;
            t = (mag * {16'd0, c}) >> 12;
            return (t > 32'd65536) ? 64'd0 : 64'(32'd65536 - t);
        endfunction

        function bit [63:0] wide(logic [31:0] q);
            return {{32{q[31]}}, q};
        endfunction

        function void advect(int dir);
            logic [31:0] nxt[CELLS];
            int k, ki, kj, kd, uu, vv, di, dj;
            bit [63:0] a, b, na, nb, acc;
            foreach (nxt[n])
                nxt[n] = '0;
            for (int i = 1; i < GRID - 1; i++)
            begin
                for (int j = 1; j < GRID - 1; j++)
                begin
                    k = i * GRID + j;
                    uu = dir * int'($signed(vel_x[k]));
                    vv = dir * int'($signed(vel_y[k]));
                    di = (uu > 0) ? 1 : -1;
                    dj = (vv > 0) ? 1 : -1;
                    a = blend_weight(uu, cour_x);
                    b = blend_weight(vv, cour_y);
                    na = 64'd65536 - a;
                    nb = 64'd65536 - b;
                    ki = (i - di) * GRID + j;
                    kj = i * GRID + (j - dj);
                    kd = (i - di) * GRID + (j - dj);
                    acc = wide(field[k]) * (a * b);
                    acc += wide(field[ki]) * (na * b);
                    acc += wide(field[kj]) * (a * nb);
                    acc += wide(field[kd]) * (na * nb);
                    acc += 64'h8000_0000_8000_0000;
                    nxt[k] = acc[63:32] ^ 32'h8000_0000;
                end
            end
            field = nxt;
        endfunction

        function void time_step();
            logic [31:0] saved[CELLS];
            longint q0, d, r;
            if (!mode)
            begin
                advect(1);
            end
            else
            begin
                saved = field;
                advect(1);
                advect(-1);
                foreach (field[k])
                begin
                    q0 = longint'($signed(saved[k]));
                    d = q0 - longint'($signed(field[k]));
                    r = q0 + (d - (d & 1)) / 2;
                    if (r > 64'sd2147483647)
                        r = 64'sd2147483647;
                    if (r < -64'sd2147483648)
                        r = -64'sd2147483648;
                    field[k] = r[31:0];
                end
                advect(1);
            end
        endfunction

        function void note(cmd_t c);
            res_t r;
            int k;
            r = '0;
            k = int'(c.row) * GRID + int'(c.col);
            case (c.opcode)
                OP_WRITE:
                begin
                    vel_x[k] = c.u_value;
                    vel_y[k] = c.v_value;
                    field[k] = c.q_value;
                end
                OP_RUN:
                begin
                    time_step();
                    r.step_done = 1'b1;
                end
                OP_READ: r.q_out = field[k];
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected item q_out=%h step_done=%b", $time, got.q_out,
                         got.step_done);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.q_out !== want.q_out)
            begin
                $display("%0t: q_out expected %h actual %h", $time, want.q_out, got.q_out);
                errors++;
            end
            if (got.step_done !== want.step_done)
            begin
                $display("%0t: step_done expected %b actual %b", $time, want.step_done,
                         got.step_done);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic done;
    res_t result;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    advect_scoreboard sb;
    int unsigned cycles = 0;

    semi_lagrangian_advection_grid u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(cmd_t c);
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        sb.note(c);
    endtask

    task automatic send_paced(cmd_t c, int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        send(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic cmd_t cell_write(int r, int c, logic [15:0] u, logic [15:0] v,
                                        logic [31:0] q);
        cmd_t x;
        x.opcode = OP_WRITE;
        x.row = r[5:0];
        x.col = c[5:0];
        x.u_value = u;
        x.v_value = v;
        x.q_value = q;
        return x;
    endfunction

    function automatic cmd_t random_item();
        cmd_t x;
        int pick;
        x = cell_write($urandom_range(63), $urandom_range(63), 16'($urandom), 16'($urandom),
                       $urandom);
        pick = $urandom_range(99);
        if (pick < 55)
            x.opcode = OP_WRITE;
        else if (pick < 96)
            x.opcode = OP_READ;
        else
            x.opcode = OP_UNUSED;
        return x;
    endfunction

    function automatic cmd_t with_op(cmd_t x, logic [1:0] op);
        x.opcode = op;
        return x;
    endfunction

    initial
    begin
        int pct;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(cell_write(0, 0, 16'h7fff, 16'h8000, 32'h7fff_ffff));
        send(cell_write(63, 63, 16'h8000, 16'h7fff, 32'h8000_0000));
        send(cell_write(1, 1, 16'h0000, 16'h0000, 32'h0000_0000));
        send(cell_write(5, 7, 16'hffff, 16'h0001, 32'hffff_ffff));
        send(with_op(cell_write(0, 0, 0, 0, 0), OP_READ));
        send(with_op(cell_write(63, 63, 0, 0, 0), OP_READ));
        send(with_op(cell_write(1, 1, 0, 0, 0), OP_READ));
        send(with_op(cell_write(5, 7, 0, 0, 0), OP_READ));
        send(with_op(cell_write(63, 63, 16'hffff, 16'hffff, 32'hffff_ffff), OP_UNUSED));
        send(with_op(cell_write(0, 0, 0, 0, 0), OP_UNUSED));
        send(with_op(cell_write(63, 63, 0, 0, 0), OP_READ));
        drain();

        for (int k = 0; k < CELLS; k++)
            send_paced(cell_write(k / GRID, k % GRID, 16'($urandom), 16'($urandom), $urandom),
                       14);
        send(with_op(random_item(), OP_RUN));
        send(with_op(cell_write(31, 31, 0, 0, 0), OP_READ));
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            pct = (ph == 0) ? 14 : ((ph == 1) ? 47 : 0);
            for (int n = 0; n < 250; n++)
                send_paced(random_item(), pct);
            drain();
            case (ph)
                0:
                begin
                    reg_write(REG_COURANT_X, 32'd0);
                    reg_write(REG_COURANT_Y, 32'd65535);
                    reg_write(REG_SCHEME_MODE, 32'd0);
                end
                1:
                begin
                    reg_write(REG_COURANT_X, 32'd65535);
                    reg_write(REG_COURANT_Y, 32'd0);
                    reg_write(REG_SCHEME_MODE, 32'd1);
                end
                default:
                begin
                    reg_write(REG_COURANT_X, {16'd0, 16'($urandom)});
                    reg_write(REG_COURANT_Y, {16'd0, 16'($urandom)});
                    reg_write(REG_SCHEME_MODE, 32'd0);
                end
            endcase
            send_paced(with_op(random_item(), OP_RUN), pct);
            for (int n = 0; n < 250; n++)
                send_paced(random_item(), pct);
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
